[src/a2b_pkg.sv]
package a2b_pkg;

    // Default width of buffer position and size counters
    localparam int SIZE_BITS_DEF = 24;

    // Annex-B start code, sent in place of the length prefix
    localparam logic [31:0] START_CODE_WORD = 32'h0000_0001;

    // Bit 7 of the NAL header must be zero
    localparam int FORBIDDEN_BIT = 7;

    // Results per input byte in the longest burst
    localparam logic [2:0] BURST_MAX = 3'd5;
    localparam logic [2:0] HEADER_SLOT = 3'd4;

    // Parser phase
    typedef enum logic [2:0] {
        PH_LEN0    = 3'd0,
        PH_LEN1    = 3'd1,
        PH_LEN2    = 3'd2,
        PH_LEN3    = 3'd3,
        PH_HEADER  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    // Status carried on every output beat
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_ZERO_LEN  = 3'd2,
        ST_OVERRUN   = 3'd3,
        ST_FORBIDDEN = 3'd4
    } t_status;

endpackage

[src/avcc_to_annexb_nal_framer.sv]
// AVCC to Annex-B NAL framer. Bytes of a length-prefixed buffer enter on the slave stream,
// one per beat (tuser[0] flags the first byte, tdata[31:8] carries the buffer size). The four
// length bytes of each NAL are absorbed with no output; the header byte then yields a burst of
// five beats (00 00 00 01 and the header, the header beat tagged with type, ref_idc, offset and
// size), and each payload byte yields one beat in the cycle after it is taken. A failed check
// flushes the held bytes (four or five beats; a short prefix yields just its own byte) and tags
// the rest of the buffer with the error. Bytes are taken, and a burst drains from the single
// output register, at one per cycle while the output is not stalled; the byte behind a burst
// holds the input off until its last beat is taken. codec_hevc selects H.264 or HEVC header
// decoding and is sampled on the header byte; write it only while the block is idle.
module avcc_to_annexb_nal_framer #(
    parameter int SIZE_BITS = a2b_pkg::SIZE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,   // codec_hevc
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,     // data_byte[7:0], buffer_size[31:8]
    input  logic        i_s_tuser,     // start_of_buffer
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,     // out_byte[7:0], nal_type[13:8], ref_idc[15:14],
                                       // nal_offset[39:16], nal_size[63:40]
    output logic [7:0]  o_m_tuser,     // nal_start[0], status[3:1], last_of_run[4], zeros
    output logic        o_m_tlast      // end_of_buffer
);

    localparam int CW = ((SIZE_BITS > 32) ? SIZE_BITS : 32) + 2;

    // parser state
    logic                 r_hevc;
    logic [SIZE_BITS-1:0] r_pos, n_pos;
    logic [SIZE_BITS-1:0] r_size, n_size;
    logic [31:0]          r_held, n_held;
    logic [SIZE_BITS-1:0] r_rem, n_rem;
    a2b_pkg::t_phase      r_phase, n_phase;
    a2b_pkg::t_status     r_err, n_err;

    // output burst register
    logic                 r_valid;
    logic [2:0]           r_k;
    logic [2:0]           r_num;
    logic [31:0]          r_bheld;
    logic [7:0]           r_byte;
    a2b_pkg::t_status     r_st;
    logic                 r_eob;
    logic                 r_nal;
    logic [5:0]           r_type;
    logic [1:0]           r_ref;
    logic [23:0]          r_off;
    logic [23:0]          r_nsz;

    // burst descriptor built from the accepted byte
    logic                 d_fire;
    logic [2:0]           d_num;
    logic [31:0]          d_held;
    a2b_pkg::t_status     d_st;
    logic                 d_eob;
    logic                 d_nal;
    logic [5:0]           d_type;
    logic [1:0]           d_ref;

    logic                 w_acc, w_last, w_take;
    logic [7:0]           w_byte;
    logic                 w_sob;
    logic [31:0]          w_bsize32;
    logic [SIZE_BITS-1:0] e_pos, e_size, e_rem;
    logic [31:0]          e_held;
    a2b_pkg::t_phase      e_phase;
    a2b_pkg::t_status     e_err;
    logic [CW-1:0]        w_pos_x, w_size_x, w_len_x;
    logic                 w_out, w_eob, w_short, w_zero, w_over, w_forb;
    logic [31:0]          w_held_sh, w_len_m1;
    logic [SIZE_BITS-1:0] w_rem_hdr, w_rem_dec;
    logic [31:0]          w_pos32;

    // handshake
    assign w_last     = (r_k == (r_num - 3'd1));
    assign w_take     = r_valid & i_m_tready;
    assign o_s_tready = !r_valid || (i_m_tready && w_last);
    assign w_acc      = i_s_tvalid & o_s_tready;

    // input fields; start of buffer clears the parse before the byte is used
    assign w_byte    = i_s_tdata[7:0];
    assign w_sob     = i_s_tuser;
    assign w_bsize32 = {8'd0, i_s_tdata[31:8]};
    assign e_pos     = w_sob ? '0 : r_pos;
    assign e_size    = w_sob ? w_bsize32[SIZE_BITS-1:0] : r_size;
    assign e_held    = w_sob ? 32'd0 : r_held;
    assign e_rem     = w_sob ? '0 : r_rem;
    assign e_phase   = w_sob ? a2b_pkg::PH_LEN0 : r_phase;
    assign e_err     = w_sob ? a2b_pkg::ST_OK : r_err;

    // range checks
    assign w_pos_x   = {{(CW-SIZE_BITS){1'b0}}, e_pos};
    assign w_size_x  = {{(CW-SIZE_BITS){1'b0}}, e_size};
    assign w_held_sh = {e_held[23:0], w_byte};
    assign w_len_x   = {{(CW-32){1'b0}}, w_held_sh};
    assign w_out     = (w_pos_x >= w_size_x);
    assign w_eob     = ((w_pos_x + CW'(1)) == w_size_x);
    assign w_short   = ((w_pos_x + CW'(4)) > w_size_x);
    assign w_zero    = (w_held_sh == 32'd0);
    assign w_over    = ((w_pos_x + CW'(1) + w_len_x) > w_size_x);
    assign w_forb    = w_byte[a2b_pkg::FORBIDDEN_BIT];
    assign w_len_m1  = e_held - 32'd1;
    assign w_rem_hdr = w_len_m1[SIZE_BITS-1:0];
    assign w_rem_dec = (e_rem != '0) ? (e_rem - SIZE_BITS'(1)) : e_rem;
    assign w_pos32   = w_pos_x[31:0];

    // next parser phase
    always_comb begin
        n_phase = r_phase;
        if (w_acc) begin
            n_phase = e_phase;
            if (!w_out) begin
                unique case (e_phase)
                    a2b_pkg::PH_LEN0:
                        n_phase = w_short ? a2b_pkg::PH_ERROR : a2b_pkg::PH_LEN1;
                    a2b_pkg::PH_LEN1: n_phase = a2b_pkg::PH_LEN2;
                    a2b_pkg::PH_LEN2: n_phase = a2b_pkg::PH_LEN3;
                    a2b_pkg::PH_LEN3:
                        n_phase = (w_zero || w_over) ? a2b_pkg::PH_ERROR : a2b_pkg::PH_HEADER;
                    a2b_pkg::PH_HEADER: begin
                        if (w_forb)
                            n_phase = a2b_pkg::PH_ERROR;
                        else if (w_rem_hdr == '0)
                            n_phase = a2b_pkg::PH_LEN0;
                        else
                            n_phase = a2b_pkg::PH_PAYLOAD;
                    end
                    a2b_pkg::PH_PAYLOAD:
                        n_phase = (w_rem_dec == '0) ? a2b_pkg::PH_LEN0 : a2b_pkg::PH_PAYLOAD;
                    a2b_pkg::PH_ERROR: n_phase = a2b_pkg::PH_ERROR;
                    default:           n_phase = a2b_pkg::PH_ERROR;
                endcase
            end
        end
    end

    // datapath state and burst descriptor
    always_comb begin
        n_pos  = e_pos;
        n_size = e_size;
        n_held = e_held;
        n_rem  = e_rem;
        n_err  = e_err;
        d_fire = 1'b1;
        d_num  = 3'd1;
        d_held = e_held;
        d_st   = e_err;
        d_eob  = w_eob;
        d_nal  = 1'b0;
        d_type = 6'd0;
        d_ref  = 2'd0;
        if (w_out) begin
            // byte outside any buffer: pass through, no state change
            d_eob = 1'b0;
        end else begin
            n_pos = e_pos + SIZE_BITS'(1);
            unique case (e_phase)
                a2b_pkg::PH_LEN0, a2b_pkg::PH_LEN1, a2b_pkg::PH_LEN2: begin
                    if (e_phase == a2b_pkg::PH_LEN0 && w_short) begin
                        n_err = a2b_pkg::ST_SHORT;
                        d_st  = a2b_pkg::ST_SHORT;
                    end else begin
                        n_held = w_held_sh;
                        d_fire = 1'b0;
                    end
                end
                a2b_pkg::PH_LEN3: begin
                    n_held = w_held_sh;
                    d_held = w_held_sh;
                    d_num  = 3'd4;
                    if (w_zero) begin
                        n_err = a2b_pkg::ST_ZERO_LEN;
                        d_st  = a2b_pkg::ST_ZERO_LEN;
                    end else if (w_over) begin
                        n_err = a2b_pkg::ST_OVERRUN;
                        d_st  = a2b_pkg::ST_OVERRUN;
                    end else begin
                        d_fire = 1'b0;
                    end
                end
                a2b_pkg::PH_HEADER: begin
                    d_num = a2b_pkg::BURST_MAX;
                    if (w_forb) begin
                        n_err = a2b_pkg::ST_FORBIDDEN;
                        d_st  = a2b_pkg::ST_FORBIDDEN;
                    end else begin
                        d_held = a2b_pkg::START_CODE_WORD;
                        d_st   = a2b_pkg::ST_OK;
                        d_nal  = 1'b1;
                        if (r_hevc) begin
                            d_type = w_byte[6:1];
                        end else begin
                            d_type = {1'b0, w_byte[4:0]};
                            d_ref  = w_byte[6:5];
                        end
                        n_rem  = w_rem_hdr;
                        n_held = 32'd0;
                    end
                end
                a2b_pkg::PH_PAYLOAD: begin
                    d_st  = a2b_pkg::ST_OK;
                    n_rem = w_rem_dec;
                    if (w_rem_dec == '0)
                        n_held = 32'd0;
                end
                default: begin
                    // error phase: pass through with the sticky code
                    d_st = e_err;
                end
            endcase
        end
    end

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hevc  <= 1'b0;
            r_pos   <= '0;
            r_size  <= '0;
            r_held  <= 32'd0;
            r_rem   <= '0;
            r_phase <= a2b_pkg::PH_LEN0;
            r_err   <= a2b_pkg::ST_OK;
        end else begin
            if (i_cfg_we)
                r_hevc <= i_cfg_wdata;
            r_phase <= n_phase;
            if (w_acc) begin
                r_pos  <= n_pos;
                r_size <= n_size;
                r_held <= n_held;
                r_rem  <= n_rem;
                r_err  <= n_err;
            end
        end
    end

    // output burst control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= 3'd0;
        end else if (w_acc && d_fire) begin
            r_valid <= 1'b1;
            r_k     <= 3'd0;
        end else if (w_take) begin
            if (w_last)
                r_valid <= 1'b0;
            else
                r_k <= r_k + 3'd1;
        end
    end

    // output burst payload
    always_ff @(posedge i_clk) begin
        if (w_acc && d_fire) begin
            r_num   <= d_num;
            r_bheld <= d_held;
            r_byte  <= w_byte;
            r_st    <= d_st;
            r_eob   <= d_eob;
            r_nal   <= d_nal;
            r_type  <= d_type;
            r_ref   <= d_ref;
            r_off   <= w_pos32[23:0];
            r_nsz   <= e_held[23:0];
        end
    end

    // beat formatting
    logic [7:0] w_obyte;
    logic       w_hdr_beat;

    assign w_hdr_beat = r_nal && (r_k == a2b_pkg::HEADER_SLOT);

    always_comb begin
        if (r_num == 3'd1 || r_k == a2b_pkg::HEADER_SLOT) begin
            w_obyte = r_byte;
        end else begin
            case (r_k[1:0])
                2'd0:    w_obyte = r_bheld[31:24];
                2'd1:    w_obyte = r_bheld[23:16];
                2'd2:    w_obyte = r_bheld[15:8];
                default: w_obyte = r_bheld[7:0];
            endcase
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tlast  = r_eob & w_last;
    assign o_m_tdata  = {w_hdr_beat ? r_nsz : 24'd0,
                         w_hdr_beat ? r_off : 24'd0,
                         w_hdr_beat ? r_ref : 2'd0,
                         w_hdr_beat ? r_type : 6'd0,
                         w_obyte};
    assign o_m_tuser  = {3'd0, w_last, r_st, w_hdr_beat};

endmodule

[src/a2b_checker.sv]
module a2b_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic [7:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // a stalled beat stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output beat dropped while stalled");

    // end of buffer only on the closing beat of a burst
    a_eob_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[4])
        else $error("end_of_buffer on a beat that is not last of run");

    // a NAL header beat is clean: status ok, forbidden bit clear, nonzero size
    a_hdr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |->
            (o_m_tuser[3:1] == 3'd0) && !o_m_tdata[7] && (o_m_tdata[63:40] != 24'd0)
            && o_m_tuser[4])
        else $error("bad NAL header beat");

    // header info is zero on every other beat
    a_info_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> (o_m_tdata[63:8] == 56'd0))
        else $error("NAL info on a non-header beat");

endmodule

bind avcc_to_annexb_nal_framer a2b_checker u_a2b_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

[sim/annexb_beat_checker.sv]
// Watches both streams of the framer, predicts the Annex-B beats for every
// accepted input byte and compares each output beat with the oldest prediction.
module annexb_beat_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,
    input  logic [7:0]  i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_pending,
    output int          o_errors
);

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             nal_start;
        logic [5:0]       nal_type;
        logic [1:0]       ref_idc;
        logic [23:0]      nal_offset;
        logic [23:0]      nal_size;
        a2b_pkg::t_status status;
        logic             eob;
        logic             last_beat;
    } t_beat;

    // expected output beats, oldest first
    t_beat annexb_q[$];

    // framer state as predicted
    logic             hevc;
    logic [23:0]      pos;
    logic [23:0]      buf_size;
    logic [31:0]      held;
    logic [23:0]      remaining;
    a2b_pkg::t_phase  phase;
    a2b_pkg::t_status err;

    initial o_errors = 0;
    initial o_pending = 0;

    function automatic t_beat plain_beat(logic [7:0] b, a2b_pkg::t_status st, logic eob);
        t_beat r;
        r = '0;
        r.out_byte = b;
        r.status = st;
        r.eob = eob;
        return r;
    endfunction

    // Work out the beats that one input byte causes and queue them
    task automatic frame_byte(input logic [7:0] d, input logic sob, input logic [23:0] sz);
        t_beat burst[5];
        int n;
        logic eob;
        longint unsigned pos64;
        longint unsigned size64;
        n = 0;
        if (sob) begin
            pos = '0;
            buf_size = sz;
            held = '0;
            remaining = '0;
            phase = a2b_pkg::PH_LEN0;
            err = a2b_pkg::ST_OK;
        end
        // byte outside any buffer: pass through, no state change
        if (pos >= buf_size) begin
            burst[0] = plain_beat(d, err, 1'b0);
            burst[0].last_beat = 1'b1;
            annexb_q.insert(annexb_q.size(), burst[0]);
            return;
        end
        pos64 = pos;
        size64 = buf_size;
        eob = (pos64 + 1 == size64);

        case (phase)
            a2b_pkg::PH_LEN0, a2b_pkg::PH_LEN1, a2b_pkg::PH_LEN2, a2b_pkg::PH_LEN3: begin
                if (phase == a2b_pkg::PH_LEN0 && pos64 + 4 > size64) begin
                    err = a2b_pkg::ST_SHORT;
                    phase = a2b_pkg::PH_ERROR;
                    burst[0] = plain_beat(d, err, eob);
                    n = 1;
                end else begin
                    held = {held[23:0], d};
                    if (phase != a2b_pkg::PH_LEN3) begin
                        phase = a2b_pkg::t_phase'(phase + 3'd1);
                    end else begin
                        if (held == 32'd0)
                            err = a2b_pkg::ST_ZERO_LEN;
                        else if (pos64 + 1 + longint'(held) > size64)
                            err = a2b_pkg::ST_OVERRUN;
                        if (err != a2b_pkg::ST_OK) begin
                            phase = a2b_pkg::PH_ERROR;
                            for (int k = 0; k < 4; k++)
                                burst[k] = plain_beat(8'(held >> (24 - 8 * k)), err, 1'b0);
                            burst[3].eob = eob;
                            n = 4;
                        end else begin
                            phase = a2b_pkg::PH_HEADER;
                        end
                    end
                end
            end
            a2b_pkg::PH_HEADER: begin
                if (d[a2b_pkg::FORBIDDEN_BIT]) begin
                    err = a2b_pkg::ST_FORBIDDEN;
                    phase = a2b_pkg::PH_ERROR;
                    for (int k = 0; k < 4; k++)
                        burst[k] = plain_beat(8'(held >> (24 - 8 * k)), err, 1'b0);
                    burst[4] = plain_beat(d, err, eob);
                    n = 5;
                end else begin
                    for (int k = 0; k < 4; k++)
                        burst[k] = plain_beat(8'(a2b_pkg::START_CODE_WORD >> (24 - 8 * k)),
                                              a2b_pkg::ST_OK, 1'b0);
                    burst[4] = plain_beat(d, a2b_pkg::ST_OK, eob);
                    burst[4].nal_start = 1'b1;
                    burst[4].nal_type = hevc ? d[6:1] : {1'b0, d[4:0]};
                    burst[4].ref_idc = hevc ? 2'd0 : d[6:5];
                    burst[4].nal_offset = pos;
                    burst[4].nal_size = held[23:0];
                    n = 5;
                    remaining = held[23:0] - 24'd1;
                    phase = (remaining == 24'd0) ? a2b_pkg::PH_LEN0 : a2b_pkg::PH_PAYLOAD;
                    held = '0;
                end
            end
            a2b_pkg::PH_PAYLOAD: begin
                burst[0] = plain_beat(d, a2b_pkg::ST_OK, eob);
                n = 1;
                if (remaining != 24'd0)
                    remaining = remaining - 24'd1;
                if (remaining == 24'd0) begin
                    phase = a2b_pkg::PH_LEN0;
                    held = '0;
                end
            end
            default: begin
                burst[0] = plain_beat(d, err, eob);
                n = 1;
            end
        endcase

        pos = pos + 24'd1;
        if (n > 0)
            burst[n - 1].last_beat = 1'b1;
        for (int k = 0; k < n; k++)
            annexb_q.insert(annexb_q.size(), burst[k]);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            o_errors++;
        end
    endtask

    // Compare one output beat with the oldest expectation
    task automatic check_beat();
        t_beat want;
        if (annexb_q.size() == 0) begin
            $display("%0t: output beat with nothing expected, expected none,", $time,
                     " got tdata=%h tuser=%h tlast=%b", i_m_tdata, i_m_tuser, i_m_tlast);
            o_errors++;
        end else begin
            want = annexb_q.pop_front();
            check_field("out_byte", want.out_byte, i_m_tdata[7:0]);
            check_field("nal_type", want.nal_type, i_m_tdata[13:8]);
            check_field("ref_idc", want.ref_idc, i_m_tdata[15:14]);
            check_field("nal_offset", want.nal_offset, i_m_tdata[39:16]);
            check_field("nal_size", want.nal_size, i_m_tdata[63:40]);
            check_field("nal_start", want.nal_start, i_m_tuser[0]);
            check_field("status", want.status, i_m_tuser[3:1]);
            check_field("last_of_run", want.last_beat, i_m_tuser[4]);
            check_field("end_of_buffer", want.eob, i_m_tlast);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hevc = 1'b0;
            pos = '0;
            buf_size = '0;
            held = '0;
            remaining = '0;
            phase = a2b_pkg::PH_LEN0;
            err = a2b_pkg::ST_OK;
            annexb_q.delete();
        end else begin
            // output first: a beat leaving now was caused by an earlier byte
            if (i_m_tvalid === 1'b1 && i_m_tready)
                check_beat();
            if (i_s_tvalid && i_s_tready === 1'b1)
                frame_byte(i_s_tdata[7:0], i_s_tuser, i_s_tdata[31:8]);
            if (i_cfg_we)
                hevc = i_cfg_wdata;
        end
        o_pending = annexb_q.size();
    end

endmodule

[sim/tb_avcc_to_annexb_nal_framer.sv]
// Drives length-prefixed buffers into the framer; the checker predicts and compares.
module tb_avcc_to_annexb_nal_framer;

    localparam int CYCLE_LIMIT = 100000;
    localparam int BYTES_PER_PASS = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;     // data_byte[7:0], buffer_size[31:8]
    logic        i_s_tuser;     // start_of_buffer
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;     // out_byte, nal_type, ref_idc, nal_offset, nal_size
    logic [7:0]  o_m_tuser;     // nal_start, status, last_of_run, zeros
    logic        o_m_tlast;     // end_of_buffer

    int pending;
    int errors;
    int cycles;
    int bytes_sent;
    bit quiet;

    // bytes of the buffer being built
    logic [7:0] nal_bytes_q[$];

    avcc_to_annexb_nal_framer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    annexb_beat_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .i_m_tlast  (o_m_tlast),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver drops ready at random, with about an 11 percent chance, never while quiet
    always @(negedge i_clk) begin
        i_m_tready <= quiet || ($urandom_range(0, 99) >= 11);
    end

    // Present one byte and hold it until it is taken
    task automatic send_byte(input logic [7:0] d, input logic sob, input logic [23:0] sz);
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < 11) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {sz, d};
        i_s_tuser <= sob;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_buffer(input logic [23:0] sz, input int count);
        for (int i = 0; i < count; i++)
            send_byte(nal_bytes_q[i], i == 0, sz);
    endtask

    // 4-byte big-endian length, header, then len-1 payload bytes
    task automatic add_nal(input int unsigned len, input logic [7:0] hdr);
        nal_bytes_q.insert(nal_bytes_q.size(), len[31:24]);
        nal_bytes_q.insert(nal_bytes_q.size(), len[23:16]);
        nal_bytes_q.insert(nal_bytes_q.size(), len[15:8]);
        nal_bytes_q.insert(nal_bytes_q.size(), len[7:0]);
        nal_bytes_q.insert(nal_bytes_q.size(), hdr);
        repeat (len - 1) nal_bytes_q.insert(nal_bytes_q.size(), 8'($urandom));
    endtask

    // Drop valid and wait until every expected beat is out, plus drain time
    task automatic settle();
        @(negedge i_clk) i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_codec(input logic hevc);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= hevc;
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // One buffer: mostly well-formed, else one of the error shapes
    task automatic random_buffer(input int kind);
        int unsigned len;
        int unsigned cut;
        int unsigned drop;
        logic [23:0] sz;
        drop = 0;
        nal_bytes_q.delete();
        repeat ($urandom_range(kind < 60 ? 1 : 0, 3))
            add_nal($urandom_range(1, 8), 8'($urandom_range(0, 127)));
        if (kind < 60) begin
            sz = 24'(nal_bytes_q.size());
            send_buffer(sz, int'(sz));
            // stray bytes past the end of the buffer
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0, 24'($urandom));
            return;
        end
        if (kind < 68) begin
            // forbidden bit in the header
            add_nal($urandom_range(1, 8), 8'($urandom_range(128, 255)));
        end else if (kind < 76) begin
            // zero length, then a tail that passes through
            repeat (4) nal_bytes_q.insert(nal_bytes_q.size(), 8'h00);
            repeat ($urandom_range(0, 3)) nal_bytes_q.insert(nal_bytes_q.size(), 8'($urandom));
        end else if (kind < 84) begin
            // NAL longer than the buffer
            if ($urandom_range(0, 1)) begin
                len = $urandom_range(1, 8);
                add_nal(len, 8'($urandom_range(0, 127)));
                drop = $urandom_range(1, len);
            end else begin
                repeat (4) nal_bytes_q.insert(nal_bytes_q.size(), 8'($urandom));
                repeat ($urandom_range(0, 2))
                    nal_bytes_q.insert(nal_bytes_q.size(), 8'($urandom));
            end
        end else if (kind < 92) begin
            // fewer than four bytes left for a prefix
            repeat ($urandom_range(1, 3)) nal_bytes_q.insert(nal_bytes_q.size(), 8'($urandom));
        end else begin
            // abandoned buffer: a new start cuts it, often inside a prefix
            cut = nal_bytes_q.size() + $urandom_range(1, 3);
            add_nal($urandom_range(1, 8), 8'($urandom_range(0, 127)));
            if ($urandom_range(0, 1))
                cut = $urandom_range(1, nal_bytes_q.size());
            if ($urandom_range(0, 3) == 0)
                sz = 24'hFF_FFFF;
            else
                sz = 24'($urandom_range(nal_bytes_q.size() + 4, 24'hFF_FFFF));
            send_buffer(sz, int'(cut));
            return;
        end
        sz = 24'(nal_bytes_q.size() - drop);
        send_buffer(sz, int'(sz));
    endtask

    initial begin
        int base;
        bit first;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        quiet = 1'b0;
        bytes_sent = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        write_codec(1'b0);

        // byte before any buffer start
        send_byte(8'hFF, 1'b0, 24'h00_0000);
        // two good NALs, the second header-only
        nal_bytes_q = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h67, 8'hFF,
                        8'h00, 8'h00, 8'h00, 8'h01, 8'h41};
        send_buffer(24'd11, 11);
        // short prefix
        nal_bytes_q = '{8'h00, 8'h7F};
        send_buffer(24'd2, 2);
        // zero length
        nal_bytes_q = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_buffer(24'd4, 4);
        // forbidden bit
        nal_bytes_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h80};
        send_buffer(24'd5, 5);
        // overrun by one
        nal_bytes_q = '{8'h00, 8'h00, 8'h00, 8'h01};
        send_buffer(24'd4, 4);

        // random passes, alternating the codec; second pass runs without idling
        for (int p = 0; p < 4; p++) begin
            write_codec(p % 2 == 0);
            quiet = (p == 1);
            base = bytes_sent;
            first = 1'b1;
            while (bytes_sent - base < BYTES_PER_PASS) begin
                random_buffer(first ? 95 : $urandom_range(0, 99));
                first = 1'b0;
            end
        end

        settle();
        repeat (20) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
